@@ rtl/vcqe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vcqe_pkg
// Shared types and constants of the voxel cell quad emitter.
// ----------------------------------------------------------------------------
package vcqe_pkg;

  localparam int unsigned MAX_DIM_DEF = 32;

  localparam int unsigned COORD_W = 5;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned DIM_W   = 6;
  localparam int unsigned ID_W    = 15;
  localparam int unsigned ENTRY_W = ID_W + 1;

  // (x+1)*63 + 32 needs 12 bits; ((x+1)*63 + 32)*63 + 32 needs 17 bits
  localparam int unsigned ROW_W = 12;
  localparam int unsigned MUL_W = ROW_W + DIM_W;
  localparam int unsigned RAW_W = 17;
  localparam int unsigned RED_W = $clog2(RAW_W);

  localparam int unsigned NCORNER = 7;
  localparam int unsigned CIDX_W  = 3;

  localparam logic [DIM_W-1:0] GRID_DIM_RST = 6'd32;

  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic KIND_VERT = 1'b0;
  localparam logic KIND_QUAD = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC1,
    ST_MAC2,
    ST_REDUCE,
    ST_READ,
    ST_CHECK,
    ST_QUAD
  } state_e;

  // lookup order: x1y0z0, x0y1z0, x1y1z0, x1y1z1, x1y0z1, x0y0z1, x0y1z1
  // returns {dx, dy, dz}
  function automatic logic [2:0] corner_off(input logic [CIDX_W-1:0] c);
    logic [2:0] r;
    r = 3'b000;
    unique case (c)
      3'd0:    r = 3'b100;
      3'd1:    r = 3'b010;
      3'd2:    r = 3'b110;
      3'd3:    r = 3'b111;
      3'd4:    r = 3'b101;
      3'd5:    r = 3'b001;
      3'd6:    r = 3'b011;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/voxel_cell_quad_emitter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_cell_quad_emitter_unit
// Blocky face extraction for one voxel cell with shared, deduplicated vertices.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. A process-cell
// command with a uniform corner mask finishes at once with no words. Otherwise
// every needed corner (four to seven) takes MAC, MAC, table read and check,
// with a quotient-estimate and a fold step before the read when MAX_DIM^3 is
// not a power of two (reciprocal-multiply fold of the table index). Then the
// quad phase steps through the right, top and front faces up to the last face
// emitted. One word leaves per cycle at most, on res_valid_o, and must be
// taken: there is no back-pressure. The clear command and reset both start a
// clearing pass over all MAX_DIM^3 entries of the vertex table (32768 by
// default), busy_o high throughout; grid_dim writes are accepted at any time.
module voxel_cell_quad_emitter_unit #(
  parameter int unsigned MAX_DIM = vcqe_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          opcode_i,
  input  wire logic [vcqe_pkg::COORD_W-1:0]  cell_x_i,
  input  wire logic [vcqe_pkg::COORD_W-1:0]  cell_y_i,
  input  wire logic [vcqe_pkg::COORD_W-1:0]  cell_z_i,
  input  wire logic [vcqe_pkg::MASK_W-1:0]   corner_mask_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vcqe_pkg::DIM_W-1:0]    cfg_grid_dim_i,
  output logic                               res_valid_o,
  output logic                               kind_o,
  output logic [vcqe_pkg::COORD_W-1:0]       vert_x_o,
  output logic [vcqe_pkg::COORD_W-1:0]       vert_y_o,
  output logic [vcqe_pkg::COORD_W-1:0]       vert_z_o,
  output logic [vcqe_pkg::ID_W-1:0]          idx_a_o,
  output logic [vcqe_pkg::ID_W-1:0]          idx_b_o,
  output logic [vcqe_pkg::ID_W-1:0]          idx_c_o,
  output logic [vcqe_pkg::ID_W-1:0]          idx_d_o,
  output logic                               last_o
);
  import vcqe_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam bit          IS_POW2     = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int unsigned EXT_W       = (IDX_W > RAW_W) ? IDX_W : RAW_W;
  localparam logic [IDX_W:0]   DEPTH_L  = (IDX_W + 1)'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  // floor(raw * RCP_L >> RSH) is the quotient or one below it
  localparam int unsigned RSH    = RAW_W + IDX_W;
  localparam int unsigned PROD_W = 2 * RAW_W + 1;
  localparam int unsigned FOLD_W = RAW_W + IDX_W + 1;
  localparam logic [RAW_W:0] RCP_L = (RAW_W + 1)'((64'd1 << RSH) / 64'(TABLE_DEPTH));

  // control
  state_e               state_q, state_d;
  logic [DIM_W-1:0]     grid_q, grid_d;
  logic [ID_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]     clr_q, clr_d;
  logic [CIDX_W-1:0]    c_q, c_d;
  logic [1:0]           qd_q, qd_d;
  logic                 red_q, red_d;
  logic                 res_valid_q, res_valid_d;

  // cell context and datapath
  logic [NCORNER-1:0]   need_q, need_d;
  logic [2:0]           flags_q, flags_d;   // {front, top, right} faces
  logic                 s_q, s_d;
  logic [COORD_W-1:0]   x_q, x_d, y_q, y_d, z_q, z_d;
  logic [RAW_W-1:0]     acc_q, acc_d;
  logic [RAW_W-1:0]     quo_q, quo_d;
  logic [IDX_W:0]       rem_q, rem_d;
  logic [IDX_W-1:0]     addr_q, addr_d;
  logic [ID_W-1:0]      ids_q [NCORNER];
  logic [ID_W-1:0]      ids_d [NCORNER];

  // result word
  logic                 kind_q, kind_d, last_q, last_d;
  logic [COORD_W-1:0]   vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  logic [ID_W-1:0]      ia_q, ia_d, ib_q, ib_d, ic_q, ic_d, id_q, id_d;

  // vertex table
  logic [ENTRY_W-1:0]   vtab_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]   rd_data_q;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;

  // shared multiply-add and modulo step
  logic [ROW_W-1:0]     mul_a;
  logic [DIM_W-1:0]     mul_b;
  logic [MUL_W-1:0]     mul_p;
  logic [EXT_W-1:0]     acc_ext;
  logic [PROD_W-1:0]    rcp_p;
  logic [FOLD_W-1:0]    fold_v;
  logic [IDX_W-1:0]     rem_nxt;

  logic [2:0]           off;
  logic [DIM_W-1:0]     cx, cy, cz;
  logic                 m_s, m_r, m_u, m_f;
  logic [NCORNER-1:0]   need_new;
  logic [CIDX_W-1:0]    first_c, next_c;
  logic                 has_next;

  assign off = corner_off(c_q);
  assign cx  = DIM_W'(x_q) + DIM_W'(off[2]);
  assign cy  = DIM_W'(y_q) + DIM_W'(off[1]);
  assign cz  = DIM_W'(z_q) + DIM_W'(off[0]);

  assign mul_p   = MUL_W'(mul_a) * MUL_W'(grid_q);
  assign acc_ext = EXT_W'(acc_q);
  assign rcp_p   = PROD_W'(acc_q) * PROD_W'(RCP_L);
  assign fold_v  = FOLD_W'(acc_q) - FOLD_W'(quo_q) * FOLD_W'(TABLE_DEPTH);
  assign rem_nxt = (rem_q >= DEPTH_L) ? IDX_W'(rem_q - DEPTH_L) : rem_q[IDX_W-1:0];
  assign rd_addr = IS_POW2 ? acc_ext[IDX_W-1:0] : rem_nxt;

  assign m_s = corner_mask_i[0];
  assign m_r = corner_mask_i[4];
  assign m_u = corner_mask_i[2];
  assign m_f = corner_mask_i[1];

  always_comb begin
    logic dr, du, df;
    dr = m_s ^ m_r;
    du = m_s ^ m_u;
    df = m_s ^ m_f;
    need_new = {du | df, df, dr | df, 1'b1, dr | du, du, dr};
  end

  always_comb begin
    first_c = CIDX_W'(NCORNER - 1);
    for (int i = NCORNER - 1; i >= 0; i--) begin
      if (need_new[i]) first_c = CIDX_W'(i);
    end
  end

  always_comb begin
    next_c   = c_q;
    has_next = 1'b0;
    for (int i = NCORNER - 1; i >= 0; i--) begin
      if (need_q[i] && (CIDX_W'(i) > c_q)) begin
        next_c   = CIDX_W'(i);
        has_next = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    grid_d      = grid_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    c_d         = c_q;
    qd_d        = qd_q;
    red_d       = red_q;
    need_d      = need_q;
    flags_d     = flags_q;
    s_d         = s_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    acc_d       = acc_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    addr_d      = addr_q;
    ids_d       = ids_q;
    res_valid_d = 1'b0;
    kind_d      = kind_q;
    last_d      = last_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    vz_d        = vz_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    ic_d        = ic_q;
    id_d        = id_q;
    mul_a       = '0;
    mul_b       = '0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = '0;

    if (cfg_valid_i) grid_d = cfg_grid_dim_i;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = IDX_W'(clr_q + 1'b1);
        if (clr_q == LAST_IDX) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (opcode_i == OP_CLEAR) begin
            cnt_d   = '0;
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else if (!((m_s == m_r) && (m_r == m_u) && (m_u == m_f))) begin
            x_d     = cell_x_i;
            y_d     = cell_y_i;
            z_d     = cell_z_i;
            s_d     = m_s;
            flags_d = {m_s ^ m_f, m_s ^ m_u, m_s ^ m_r};
            need_d  = need_new;
            c_d     = first_c;
            state_d = ST_MAC1;
          end
        end
      end
      ST_MAC1: begin
        // x*d + y
        mul_a   = ROW_W'(cx);
        mul_b   = cy;
        acc_d   = RAW_W'(mul_p + MUL_W'(mul_b));
        state_d = ST_MAC2;
      end
      ST_MAC2: begin
        // (x*d + y)*d + z
        mul_a   = acc_q[ROW_W-1:0];
        mul_b   = cz;
        acc_d   = RAW_W'(mul_p + MUL_W'(mul_b));
        red_d   = 1'b0;
        rem_d   = '0;
        state_d = IS_POW2 ? ST_READ : ST_REDUCE;
      end
      ST_REDUCE: begin
        // quotient estimate, then fold; one subtract is left for the address
        if (!red_q) begin
          quo_d = RAW_W'(rcp_p >> RSH);
          red_d = 1'b1;
        end else begin
          rem_d   = (IDX_W + 1)'(fold_v);
          red_d   = 1'b0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        addr_d  = rd_addr;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (rd_data_q[ENTRY_W-1]) begin
          ids_d[c_q] = rd_data_q[ID_W-1:0];
        end else begin
          ids_d[c_q]  = cnt_q;
          mem_we      = 1'b1;
          mem_wdata   = {1'b1, cnt_q};
          cnt_d       = ID_W'(cnt_q + 1'b1);
          res_valid_d = 1'b1;
          kind_d      = KIND_VERT;
          last_d      = 1'b0;
          vx_d        = cx[COORD_W-1:0];
          vy_d        = cy[COORD_W-1:0];
          vz_d        = cz[COORD_W-1:0];
          ia_d        = cnt_q;
          ib_d        = '0;
          ic_d        = '0;
          id_d        = '0;
        end
        if (has_next) begin
          c_d     = next_c;
          state_d = ST_MAC1;
        end else begin
          qd_d    = '0;
          state_d = ST_QUAD;
        end
      end
      ST_QUAD: begin
        kind_d = KIND_QUAD;
        vx_d   = '0;
        vy_d   = '0;
        vz_d   = '0;
        qd_d   = 2'(qd_q + 1'b1);
        unique case (qd_q)
          2'd0: begin
            res_valid_d = flags_q[0];
            last_d      = !(flags_q[1] | flags_q[2]);
            if (s_q) begin
              ia_d = ids_q[0]; ib_d = ids_q[2]; ic_d = ids_q[3]; id_d = ids_q[4];
            end else begin
              ia_d = ids_q[3]; ib_d = ids_q[2]; ic_d = ids_q[0]; id_d = ids_q[4];
            end
            if (flags_q[0] && last_d) state_d = ST_IDLE;
          end
          2'd1: begin
            res_valid_d = flags_q[1];
            last_d      = !flags_q[2];
            if (!s_q) begin
              ia_d = ids_q[1]; ib_d = ids_q[2]; ic_d = ids_q[3]; id_d = ids_q[6];
            end else begin
              ia_d = ids_q[3]; ib_d = ids_q[2]; ic_d = ids_q[1]; id_d = ids_q[6];
            end
            if (flags_q[1] && last_d) state_d = ST_IDLE;
          end
          default: begin
            res_valid_d = flags_q[2];
            last_d      = 1'b1;
            if (s_q) begin
              ia_d = ids_q[5]; ib_d = ids_q[4]; ic_d = ids_q[3]; id_d = ids_q[6];
            end else begin
              ia_d = ids_q[3]; ib_d = ids_q[4]; ic_d = ids_q[5]; id_d = ids_q[6];
            end
            state_d = ST_IDLE;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      grid_q      <= GRID_DIM_RST;
      cnt_q       <= '0;
      clr_q       <= '0;
      c_q         <= '0;
      qd_q        <= '0;
      red_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      grid_q      <= grid_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      c_q         <= c_d;
      qd_q        <= qd_d;
      red_q       <= red_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q  <= need_d;
    flags_q <= flags_d;
    s_q     <= s_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    acc_q   <= acc_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    addr_q  <= addr_d;
    ids_q   <= ids_d;
    kind_q  <= kind_d;
    last_q  <= last_d;
    vx_q    <= vx_d;
    vy_q    <= vy_d;
    vz_q    <= vz_d;
    ia_q    <= ia_d;
    ib_q    <= ib_d;
    ic_q    <= ic_d;
    id_q    <= id_d;
  end

  // vertex table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) vtab_mem[mem_waddr] <= mem_wdata;
    rd_data_q <= vtab_mem[rd_addr];
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign kind_o      = kind_q;
  assign vert_x_o    = vx_q;
  assign vert_y_o    = vy_q;
  assign vert_z_o    = vz_q;
  assign idx_a_o     = ia_q;
  assign idx_b_o     = ib_q;
  assign idx_c_o     = ic_q;
  assign idx_d_o     = id_q;
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  a_no_word_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !res_valid_o)
    else $error("result word during table clear");

  a_vert_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (kind_o == KIND_VERT)) |-> !last_o)
    else $error("vertex word flagged last");

  a_vert_id_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (kind_o == KIND_VERT)) |-> (idx_a_o == ID_W'(cnt_q - 1'b1)))
    else $error("new vertex id does not match counter");
`endif

endmodule
`default_nettype wire

@@ bench/voxel_cell_quad_emitter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_cell_quad_emitter_unit_tb
// Self-checking bench for the voxel cell quad emitter. A short directed plan
// covers the corner-mask cases, wrapped coordinates and the clear command;
// random cells follow over several grid_dim settings and sender idle rates.
// Every output word is checked field by field against a local vertex table
// model, in order.
// ----------------------------------------------------------------------------
module voxel_cell_quad_emitter_unit_tb;
  import vcqe_pkg::*;

  localparam int SLOTS       = 32768;
  localparam int STALL_LIMIT = 150000;
  localparam int SETTLE      = 40;
  localparam int NPHASE      = 7;
  localparam int PHASE_CELLS = 38;

  typedef struct {
    logic        kind;
    logic [4:0]  vx, vy, vz;
    logic [14:0] a, b, c, d;
    logic        last;
  } mesh_word_t;

  typedef struct {
    logic       op;
    logic [4:0] x, y, z;
    logic [7:0] m;
    int         want;   // -1: words come from the model only
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        opcode_i;
  logic [4:0]  cell_x_i, cell_y_i, cell_z_i;
  logic [7:0]  corner_mask_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [5:0]  cfg_grid_dim_i;
  logic        res_valid_o;
  logic        kind_o;
  logic [4:0]  vert_x_o, vert_y_o, vert_z_o;
  logic [14:0] idx_a_o, idx_b_o, idx_c_o, idx_d_o;
  logic        last_o;

  voxel_cell_quad_emitter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .cell_z_i      (cell_z_i),
    .corner_mask_i (corner_mask_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_grid_dim_i(cfg_grid_dim_i),
    .res_valid_o   (res_valid_o),
    .kind_o        (kind_o),
    .vert_x_o      (vert_x_o),
    .vert_y_o      (vert_y_o),
    .vert_z_o      (vert_z_o),
    .idx_a_o       (idx_a_o),
    .idx_b_o       (idx_b_o),
    .idx_c_o       (idx_c_o),
    .idx_d_o       (idx_d_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---- mesh model -----------------------------------------------------------
  logic [15:0] vtab [SLOTS];   // bit 15 assigned, 14..0 id
  logic [15:0] vcount;
  logic [5:0]  gdim;
  mesh_word_t  staged [10];
  int          staged_n;
  mesh_word_t  mesh_words [$];
  int          n_errors = 0;
  int          n_words = 0;
  int          idle_cycles = 0;

  function automatic void clear_table();
    foreach (vtab[i]) vtab[i] = '0;
    vcount = '0;
  endfunction

  function automatic void stage(logic kind, logic [4:0] vx, logic [4:0] vy,
                                logic [4:0] vz, logic [14:0] a, logic [14:0] b,
                                logic [14:0] c, logic [14:0] d);
    staged[staged_n] = '{kind, vx, vy, vz, a, b, c, d, 1'b0};
    staged_n++;
  endfunction

  function automatic logic [14:0] vertex_id(int unsigned x, int unsigned y,
                                            int unsigned z);
    int unsigned slot;
    logic [14:0] id;
    slot = ((x * gdim + y) * gdim + z) % SLOTS;
    if (vtab[slot][15]) return vtab[slot][14:0];
    id = vcount[14:0];
    vtab[slot] = {1'b1, id};
    vcount = vcount + 16'd1;
    stage(KIND_VERT, 5'(x), 5'(y), 5'(z), id, '0, '0, '0);
    return id;
  endfunction

  function automatic int extract_cell(int unsigned x, int unsigned y,
                                      int unsigned z, logic [7:0] m);
    logic s, sr, su, sf;
    logic [14:0] a100, a010, a110, a111, a101, a001, a011;
    s  = m[0];
    sr = m[4];
    su = m[2];
    sf = m[1];
    if (s == sr && sr == su && su == sf) return 0;
    staged_n = 0;
    a100 = '0; a010 = '0; a110 = '0; a101 = '0; a001 = '0; a011 = '0;
    // fixed lookup order; a corner is touched only if some face needs it
    if (s != sr)             a100 = vertex_id(x + 1, y, z);
    if (s != su)             a010 = vertex_id(x, y + 1, z);
    if (s != sr || s != su)  a110 = vertex_id(x + 1, y + 1, z);
    a111 = vertex_id(x + 1, y + 1, z + 1);
    if (s != sr || s != sf)  a101 = vertex_id(x + 1, y, z + 1);
    if (s != sf)             a001 = vertex_id(x, y, z + 1);
    if (s != su || s != sf)  a011 = vertex_id(x, y + 1, z + 1);

    if (s && !sr)      stage(KIND_QUAD, '0, '0, '0, a100, a110, a111, a101);
    else if (!s && sr) stage(KIND_QUAD, '0, '0, '0, a111, a110, a100, a101);
    if (!s && su)      stage(KIND_QUAD, '0, '0, '0, a010, a110, a111, a011);
    else if (s && !su) stage(KIND_QUAD, '0, '0, '0, a111, a110, a010, a011);
    if (s && !sf)      stage(KIND_QUAD, '0, '0, '0, a001, a101, a111, a011);
    else if (!s && sf) stage(KIND_QUAD, '0, '0, '0, a111, a101, a001, a011);

    staged[staged_n - 1].last = 1'b1;
    for (int i = 0; i < staged_n; i++) mesh_words = {mesh_words, staged[i]};
    return staged_n;
  endfunction

  // ---- checking -------------------------------------------------------------
  task automatic flag(string msg);
    $display("%0t ERROR %s", $time, msg);
    n_errors++;
  endtask

  always @(posedge clk_i) begin : check_words
    mesh_word_t w;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (mesh_words.size() == 0) begin
        flag($sformatf("word %0d arrived with nothing expected", n_words));
      end else begin
        w = mesh_words.pop_front();
        if (kind_o !== w.kind)
          flag($sformatf("word %0d kind %0h want %0h", n_words, kind_o, w.kind));
        if (vert_x_o !== w.vx)
          flag($sformatf("word %0d vert_x %0d want %0d", n_words, vert_x_o, w.vx));
        if (vert_y_o !== w.vy)
          flag($sformatf("word %0d vert_y %0d want %0d", n_words, vert_y_o, w.vy));
        if (vert_z_o !== w.vz)
          flag($sformatf("word %0d vert_z %0d want %0d", n_words, vert_z_o, w.vz));
        if (idx_a_o !== w.a)
          flag($sformatf("word %0d idx_a %0d want %0d", n_words, idx_a_o, w.a));
        if (idx_b_o !== w.b)
          flag($sformatf("word %0d idx_b %0d want %0d", n_words, idx_b_o, w.b));
        if (idx_c_o !== w.c)
          flag($sformatf("word %0d idx_c %0d want %0d", n_words, idx_c_o, w.c));
        if (idx_d_o !== w.d)
          flag($sformatf("word %0d idx_d %0d want %0d", n_words, idx_d_o, w.d));
        if (last_o !== w.last)
          flag($sformatf("word %0d last %0h want %0h", n_words, last_o, w.last));
      end
      n_words++;
    end
  end

  // clearing passes run over the whole table with no handshake, so the limit is wide
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("voxel_cell_quad_emitter_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- stimulus -------------------------------------------------------------
  task automatic issue_cmd(logic op, logic [4:0] x, logic [4:0] y, logic [4:0] z,
                           logic [7:0] m, output int nres);
    start_i       <= 1'b1;
    opcode_i      <= op;
    cell_x_i      <= x;
    cell_y_i      <= y;
    cell_z_i      <= z;
    corner_mask_i <= m;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (op == OP_CLEAR) begin
      clear_table();
      nres = 0;
    end else begin
      nres = extract_cell(x, y, z, m);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (mesh_words.size() != 0) @(posedge clk_i);
  endtask

  // uniform cells and clears give no word, so also wait out busy
  task automatic set_grid_dim(logic [5:0] v);
    drain();
    while (busy_o) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_grid_dim_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gdim = v;
    cfg_valid_i <= 1'b0;
  endtask

  cmd_row_t plan [21] = '{
    '{OP_CELL,  5'd0,  5'd0,  5'd0,  8'h01, 10},  // fresh table: 7 vertices, 3 quads
    '{OP_CELL,  5'd0,  5'd0,  5'd0,  8'h01, 3},   // all corners known
    '{OP_CELL,  5'd3,  5'd3,  5'd3,  8'h00, 0},
    '{OP_CELL,  5'd3,  5'd3,  5'd3,  8'h17, 0},
    '{OP_CELL,  5'd31, 5'd31, 5'd31, 8'hE8, 0},   // unused bits only
    '{OP_CELL,  5'd31, 5'd31, 5'd31, 8'hFF, 0},
    '{OP_CELL,  5'd31, 5'd31, 5'd31, 8'h10, -1},  // right face, coords wrap to 0
    '{OP_CELL,  5'd0,  5'd31, 5'd0,  8'h04, -1},
    '{OP_CELL,  5'd31, 5'd0,  5'd0,  8'h02, -1},
    '{OP_CELL,  5'd1,  5'd2,  5'd3,  8'h1E, -1},  // empty own corner, reversed winding
    '{OP_CELL,  5'd1,  5'd2,  5'd3,  8'h11, -1},
    '{OP_CELL,  5'd1,  5'd2,  5'd4,  8'h05, -1},
    '{OP_CELL,  5'd2,  5'd2,  5'd3,  8'h03, -1},
    '{OP_CELL,  5'd0,  5'd0,  5'd31, 8'h14, -1},
    '{OP_CELL,  5'd30, 5'd1,  5'd17, 8'hED, -1},
    '{OP_CELL,  5'd10, 5'd21, 5'd5,  8'h12, -1},
    '{OP_CELL,  5'd0,  5'd0,  5'd0,  8'h06, -1},
    '{OP_CLEAR, 5'd31, 5'd31, 5'd31, 8'hFF, 0},
    '{OP_CELL,  5'd0,  5'd0,  5'd0,  8'h01, 10},  // ids restart after clear
    '{OP_CELL,  5'd31, 5'd31, 5'd31, 8'hEF, -1},
    '{OP_CELL,  5'd16, 5'd8,  5'd4,  8'h0E, -1}
  };

  logic [5:0] phase_dim  [NPHASE] = '{6'd2, 6'd63, 6'd0, 6'd17, 6'd1, 6'd32, 6'd5};
  int         phase_idle [NPHASE] = '{0, 76, 38, 0, 76, 38, 0};

  initial begin
    int nres, cells, clears_left, pct;
    bit wide;
    logic [7:0] m;
    logic [4:0] x, y, z;

    rst_ni         = 1'b0;
    start_i        = 1'b0;
    opcode_i       = OP_CELL;
    cell_x_i       = '0;
    cell_y_i       = '0;
    cell_z_i       = '0;
    corner_mask_i  = '0;
    cfg_valid_i    = 1'b0;
    cfg_grid_dim_i = GRID_DIM_RST;
    clears_left    = 3;
    gdim           = GRID_DIM_RST;
    clear_table();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      issue_cmd(plan[i].op, plan[i].x, plan[i].y, plan[i].z, plan[i].m, nres);
      if (plan[i].want >= 0 && nres != plan[i].want)
        flag($sformatf("plan row %0d: %0d words modeled, %0d listed",
                       i, nres, plan[i].want));
    end

    for (int p = 0; p < NPHASE; p++) begin
      set_grid_dim(phase_dim[p]);
      pct   = phase_idle[p];
      cells = 0;
      while (cells < PHASE_CELLS) begin
        if (pct > 0 && $urandom_range(99) < pct) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
        end else if ($urandom_range(99) < 2) begin
          drain();
        end
        wide = ($urandom_range(99) < 20);
        x = wide ? 5'($urandom_range(31)) : 5'($urandom_range(3));
        y = wide ? 5'($urandom_range(31)) : 5'($urandom_range(3));
        z = wide ? 5'($urandom_range(31)) : 5'($urandom_range(3));
        m = 8'($urandom_range(255));
        if (clears_left > 0 && $urandom_range(99) < 2) begin
          clears_left--;
          issue_cmd(OP_CLEAR, x, y, z, m, nres);
        end else if ($urandom_range(99) < 8) begin
          // uniform used bits, random don't-care bits
          m = $urandom_range(1) ? (m | 8'h17) : (m & ~8'h17);
          issue_cmd(OP_CELL, x, y, z, m, nres);
        end else begin
          while (m[0] == m[4] && m[4] == m[2] && m[2] == m[1])
            m = 8'($urandom_range(255));
          issue_cmd(OP_CELL, x, y, z, m, nres);
          cells++;
        end
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (mesh_words.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("voxel_cell_quad_emitter_unit_tb: PASS");
    end else begin
      $display("voxel_cell_quad_emitter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
